### rtl/ordered_list_insert_delete_search_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the ordered list block.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_INSERT_DELETE_SEARCH_DEFINES_SVH
`define ORDERED_LIST_INSERT_DELETE_SEARCH_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define OLIDS_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define OLIDS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/olids_pkg.sv
// ----------------------------------------------------------------------------
// olids_pkg
// Types and constants shared by the ordered list cells, scanner and top level.
// ----------------------------------------------------------------------------
package olids_pkg;

    localparam int ENTRY_W    = 32;  // width of one list entry
    localparam int POS_W      = 5;   // position, found position, count fields
    localparam int KIND_W     = 3;
    localparam int STAT_W     = 3;
    localparam int IDX_MAX_W  = 8;   // 0-based cell index, capacity up to 256
    localparam int CNT_MAX_W  = 9;   // 1-based position or count, up to 256
    localparam int S_TDATA_W  = 40;  // value, position, padded to bytes
    localparam int M_TDATA_W  = 16;  // status, found position, count, padded

    typedef enum logic [KIND_W-1:0] {
        KIND_INS_HEAD = 3'd0,
        KIND_INS_TAIL = 3'd1,
        KIND_INS_POS  = 3'd2,
        KIND_DEL_HEAD = 3'd3,
        KIND_DEL_TAIL = 3'd4,
        KIND_DEL_POS  = 3'd5,
        KIND_SEARCH   = 3'd6
    } kind_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 3'd0,
        STAT_EMPTY    = 3'd1,
        STAT_BADPOS   = 3'd2,
        STAT_FULL     = 3'd3,
        STAT_NOTFOUND = 3'd4
    } status_t;

    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_SCAN = 1'b1
    } state_t;

    // Broadcast to every cell: shift the row for an insert or a delete.
    typedef struct packed {
        logic                 ins;
        logic                 del;
        logic [IDX_MAX_W-1:0] idx;
    } cell_ctrl_t;

    // Scanner report toward the control.
    typedef struct packed {
        logic                 done;
        logic                 hit;
        logic [CNT_MAX_W-1:0] pos;
    } scan_res_t;

endpackage

### rtl/olids_cell.sv
// ----------------------------------------------------------------------------
// olids_cell
// One list slot: holds an entry, shifts with its neighbors, compares.
// ----------------------------------------------------------------------------
module olids_cell #(
    parameter int INDEX = 0
) (
    input  logic                             aclk,
    input  olids_pkg::cell_ctrl_t            ctrl,
    input  logic [olids_pkg::ENTRY_W-1:0]    value_in,
    input  logic [olids_pkg::ENTRY_W-1:0]    left_in,
    input  logic [olids_pkg::ENTRY_W-1:0]    right_in,
    output logic [olids_pkg::ENTRY_W-1:0]    entry_out,
    output logic                             match_out
);

    logic [olids_pkg::ENTRY_W-1:0] entry_reg;
    logic [olids_pkg::ENTRY_W-1:0] entry_next;
    int                            idx_i;

    assign idx_i = int'(ctrl.idx);

    always_comb begin
        entry_next = entry_reg;
        priority if (ctrl.ins && (INDEX > idx_i)) begin
            entry_next = left_in;           // take the neighbor toward the head
        end else if (ctrl.ins && (INDEX == idx_i)) begin
            entry_next = value_in;          // land the new value here
        end else if (ctrl.del && (INDEX >= idx_i)) begin
            entry_next = right_in;          // close the gap from the tail side
        end else begin
            entry_next = entry_reg;         // hold
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry_out = entry_reg;
    assign match_out = (entry_reg == value_in);

endmodule

### rtl/olids_scan.sv
// ----------------------------------------------------------------------------
// olids_scan
// Walks the captured match vector one cell per cycle to find the first hit.
// ----------------------------------------------------------------------------
module olids_scan #(
    parameter int CAPACITY = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  load,
    input  logic [CAPACITY-1:0]   vec_in,
    input  logic [$clog2(CAPACITY)-1:0] last_in,
    input  logic                  ack,
    output olids_pkg::scan_res_t  res
);

    localparam int IW = $clog2(CAPACITY);

    logic                busy_reg, busy_next;
    logic [CAPACITY-1:0] vec_reg, vec_next;
    logic [IW-1:0]       idx_reg, idx_next;
    logic [IW-1:0]       last_reg, last_next;
    logic                done;

    assign done = busy_reg && (vec_reg[0] || (idx_reg == last_reg));

    always_comb begin
        busy_next = busy_reg;
        vec_next  = vec_reg;
        idx_next  = idx_reg;
        last_next = last_reg;
        priority if (load) begin
            busy_next = 1'b1;
            vec_next  = vec_in;
            idx_next  = '0;
            last_next = last_in;
        end else if (done) begin
            if (ack) begin
                busy_next = 1'b0;           // hold the answer until taken
            end
        end else if (busy_reg) begin
            vec_next = vec_reg >> 1;        // advance one cell
            idx_next = idx_reg + IW'(1);
        end else begin
            busy_next = busy_reg;           // idle: hold
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        vec_reg  <= vec_next;
        idx_reg  <= idx_next;
        last_reg <= last_next;
    end

    assign res.done = done;
    assign res.hit  = vec_reg[0];
    assign res.pos  = olids_pkg::CNT_MAX_W'(idx_reg) + olids_pkg::CNT_MAX_W'(1);

endmodule

### rtl/ordered_list_insert_delete_search.sv
// Timing: insert, delete and unused kinds put their result beat in the output
//   register in the cycle after the input beat; a search's beat follows the scan.
// Throughput: one item per cycle while the result side keeps up; a search holds
//   input off until the first-match scan is done and its result is taken.
// Reset: aresetn (synchronous, active low) clears the count, the state machine
//   and the output valid; entries stay undefined and need no clearing pass.
// ----------------------------------------------------------------------------
// ordered_list_insert_delete_search
// Ordered list of signed 32-bit values kept in a row of shifting cells, with
// insert, delete and first-match search on a stream interface.
// ----------------------------------------------------------------------------
`include "ordered_list_insert_delete_search_defines.svh"

module ordered_list_insert_delete_search #(
    parameter int CAPACITY = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input beat
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [31:0] value, [36:32] position, [39:37] zero
    input  logic [olids_pkg::S_TDATA_W-1:0]   s_tdata,
    // [2:0] kind
    input  logic [olids_pkg::KIND_W-1:0]      s_tuser,
    // result beat
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [2:0] status, [7:3] found_position, [12:8] entry_count, [15:13] zero
    output logic [olids_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int CW = $clog2(CAPACITY + 1);          // count width
    localparam int IW = $clog2(CAPACITY);              // cell index width
    localparam int PW = ((CW > olids_pkg::POS_W) ? CW : olids_pkg::POS_W) + 1;

    // ------------------------------------------------------------------
    // Input fields
    // ------------------------------------------------------------------
    logic                              s_fire;
    logic [olids_pkg::ENTRY_W-1:0]     in_value;
    logic [olids_pkg::POS_W-1:0]       in_pos;
    logic [PW-1:0]                     pos_ext;
    logic [PW-1:0]                     cnt_ext;

    assign s_fire   = s_tvalid && s_tready;
    assign in_value = s_tdata[olids_pkg::ENTRY_W-1:0];
    assign in_pos   = s_tdata[olids_pkg::ENTRY_W +: olids_pkg::POS_W];
    assign pos_ext  = PW'(in_pos);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    olids_pkg::state_t                 state_reg, state_next;
    logic [CW-1:0]                     count_reg, count_next;
    logic                              m_valid_reg, m_valid_next;
    olids_pkg::status_t                m_status_reg, m_status_next;
    logic [olids_pkg::POS_W-1:0]       m_found_reg, m_found_next;
    logic [olids_pkg::POS_W-1:0]       m_count_reg, m_count_next;

    assign cnt_ext = PW'(count_reg);

    // ------------------------------------------------------------------
    // Decode: pick the target cell and the immediate status
    // ------------------------------------------------------------------
    logic                  ins_ok;
    logic                  del_ok;
    logic                  srch_scan;
    logic [IW-1:0]         tgt_idx;
    olids_pkg::status_t    imm_status;
    logic                  list_empty;
    logic                  list_full;

    assign list_empty = (count_reg == '0);
    assign list_full  = (count_reg == CW'(CAPACITY));

    always_comb begin
        ins_ok     = 1'b0;
        del_ok     = 1'b0;
        srch_scan  = 1'b0;
        tgt_idx    = '0;
        imm_status = olids_pkg::STAT_OK;
        unique case (s_tuser)
            olids_pkg::KIND_INS_HEAD,
            olids_pkg::KIND_INS_TAIL,
            olids_pkg::KIND_INS_POS: begin
                // full list wins over a bad position
                priority if (list_full) begin
                    imm_status = olids_pkg::STAT_FULL;
                end else if (list_empty || (s_tuser == olids_pkg::KIND_INS_HEAD)) begin
                    ins_ok = 1'b1;
                end else if (s_tuser == olids_pkg::KIND_INS_TAIL) begin
                    ins_ok  = 1'b1;
                    tgt_idx = count_reg[IW-1:0];
                end else if (pos_ext <= PW'(1)) begin
                    ins_ok = 1'b1;
                end else if (pos_ext <= (cnt_ext + PW'(1))) begin
                    ins_ok  = 1'b1;
                    tgt_idx = IW'(pos_ext - PW'(1));
                end else begin
                    imm_status = olids_pkg::STAT_BADPOS;
                end
            end
            olids_pkg::KIND_DEL_HEAD,
            olids_pkg::KIND_DEL_TAIL,
            olids_pkg::KIND_DEL_POS: begin
                priority if (list_empty) begin
                    imm_status = olids_pkg::STAT_EMPTY;
                end else if (s_tuser == olids_pkg::KIND_DEL_HEAD) begin
                    del_ok = 1'b1;
                end else if (s_tuser == olids_pkg::KIND_DEL_TAIL) begin
                    del_ok  = 1'b1;
                    tgt_idx = IW'(count_reg - CW'(1));
                end else if (pos_ext <= PW'(1)) begin
                    del_ok = 1'b1;
                end else if (pos_ext <= cnt_ext) begin
                    del_ok  = 1'b1;
                    tgt_idx = IW'(pos_ext - PW'(1));
                end else begin
                    imm_status = olids_pkg::STAT_BADPOS;
                end
            end
            olids_pkg::KIND_SEARCH: begin
                if (list_empty) begin
                    imm_status = olids_pkg::STAT_EMPTY;
                end else begin
                    srch_scan = 1'b1;       // answer comes from the scanner
                end
            end
            default: begin
                // unused kind: no operation, status ok
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Cell row
    // ------------------------------------------------------------------
    olids_pkg::cell_ctrl_t             cell_ctrl;
    logic [olids_pkg::ENTRY_W-1:0]     entry_w [CAPACITY];
    logic [CAPACITY-1:0]               match_w;
    logic [CAPACITY-1:0]               match_live;

    assign cell_ctrl.ins = s_fire && ins_ok;
    assign cell_ctrl.del = s_fire && del_ok;
    assign cell_ctrl.idx = olids_pkg::IDX_MAX_W'(tgt_idx);

    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        // end cells feed themselves where no neighbor exists; the tail cell
        // keeps its own entry on a delete
        olids_cell #(
            .INDEX (gi)
        ) u_cell (
            .aclk      (aclk),
            .ctrl      (cell_ctrl),
            .value_in  (in_value),
            .left_in   (entry_w[(gi == 0) ? 0 : gi - 1]),
            .right_in  (entry_w[(gi == CAPACITY - 1) ? gi : gi + 1]),
            .entry_out (entry_w[gi]),
            .match_out (match_w[gi])
        );
        // only cells inside the list may match
        assign match_live[gi] = match_w[gi] && (CW'(gi) < count_reg);
    end

    // ------------------------------------------------------------------
    // First-match scanner
    // ------------------------------------------------------------------
    logic                  out_free;
    olids_pkg::scan_res_t  scan_res;

    assign out_free = !m_valid_reg || m_tready;

    olids_scan #(
        .CAPACITY (CAPACITY)
    ) u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (s_fire && srch_scan),
        .vec_in  (match_live),
        .last_in (IW'(count_reg - CW'(1))),
        .ack     (out_free),
        .res     (scan_res)
    );

    // ------------------------------------------------------------------
    // State machine: next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            olids_pkg::ST_IDLE: begin
                if (s_fire && srch_scan) begin
                    state_next = olids_pkg::ST_SCAN;
                end
            end
            olids_pkg::ST_SCAN: begin
                if (scan_res.done && out_free) begin
                    state_next = olids_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = olids_pkg::ST_IDLE;
            end
        endcase
    end

    // State machine: outputs
    always_comb begin
        s_tready = 1'b0;
        unique case (state_reg)
            olids_pkg::ST_IDLE: s_tready = out_free;
            olids_pkg::ST_SCAN: s_tready = 1'b0;
            default:            s_tready = 1'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // Count and output register
    // ------------------------------------------------------------------
    always_comb begin
        count_next = count_reg;
        if (cell_ctrl.ins) begin
            count_next = count_reg + CW'(1);
        end else if (cell_ctrl.del) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_comb begin
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_found_next  = m_found_reg;
        m_count_next  = m_count_reg;
        priority if (s_fire && !srch_scan) begin
            m_valid_next  = 1'b1;
            m_status_next = imm_status;
            m_found_next  = '0;
            m_count_next  = olids_pkg::POS_W'(count_next);
        end else if ((state_reg == olids_pkg::ST_SCAN) && scan_res.done && out_free) begin
            m_valid_next  = 1'b1;
            m_status_next = scan_res.hit ? olids_pkg::STAT_OK : olids_pkg::STAT_NOTFOUND;
            m_found_next  = scan_res.hit ? olids_pkg::POS_W'(scan_res.pos) : '0;
            m_count_next  = olids_pkg::POS_W'(count_reg);
        end else if (m_tready) begin
            m_valid_next  = 1'b0;           // drop the beat once taken
        end else begin
            m_valid_next  = m_valid_reg;    // hold the beat until taken
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= olids_pkg::ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        m_status_reg <= m_status_next;
        m_found_reg  <= m_found_next;
        m_count_reg  <= m_count_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_count_reg, m_found_reg, m_status_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `OLIDS_ASSERT_IMPL(a_count_range, aclk, aresetn, 1'b1, count_reg <= CW'(CAPACITY), "olids: count above capacity")
    `OLIDS_ASSERT_NEXT(a_full_hold, aclk, aresetn, s_fire && list_full && ((s_tuser == olids_pkg::KIND_INS_HEAD) || (s_tuser == olids_pkg::KIND_INS_TAIL) || (s_tuser == olids_pkg::KIND_INS_POS)), count_reg == $past(count_reg), "olids: insert into full list changed count")
    `OLIDS_ASSERT_IMPL(a_hit_in_list, aclk, aresetn, (state_reg == olids_pkg::ST_SCAN) && scan_res.done && scan_res.hit, scan_res.pos <= olids_pkg::CNT_MAX_W'(count_reg), "olids: search hit beyond list end")

endmodule

### dv/ordered_list_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ordered_list_checker
// Watches both stream channels of the ordered list block. Keeps its own copy
// of the list, works out the result of every accepted input beat and compares
// each result beat with the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module ordered_list_checker #(
    parameter int CAPACITY = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    // [31:0] value, [36:32] position, [39:37] zero
    input  logic [olids_pkg::S_TDATA_W-1:0] s_tdata,
    // [2:0] kind
    input  logic [olids_pkg::KIND_W-1:0]    s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    // [2:0] status, [7:3] found_position, [12:8] entry_count, [15:13] zero
    input  logic [olids_pkg::M_TDATA_W-1:0] m_tdata,
    output int                              fail_count,
    output int                              pending
);
    import olids_pkg::*;

    localparam int FOUND_LSB = STAT_W;
    localparam int COUNT_LSB = STAT_W + POS_W;

    typedef struct packed {
        status_t          status;
        logic [POS_W-1:0] found_pos;
        logic [POS_W-1:0] entry_count;
    } list_result_t;

    logic signed [ENTRY_W-1:0] list_mem [CAPACITY];
    int                        list_len;
    list_result_t              result_q [$];
    list_result_t              want;

    function automatic void insert_entry(int idx, logic signed [ENTRY_W-1:0] v);
        for (int i = list_len; i > idx; i--) list_mem[i] = list_mem[i-1];
        list_mem[idx] = v;
        list_len++;
    endfunction

    function automatic void remove_entry(int idx);
        for (int i = idx; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
        list_len--;
    endfunction

    // Apply one operation to the shadow list and return what the block should report.
    function automatic list_result_t apply_list_op(logic [KIND_W-1:0] kind,
                                                   logic signed [ENTRY_W-1:0] value,
                                                   logic [POS_W-1:0] pos);
        list_result_t r;
        int           p;
        bit           hit;
        r.status    = STAT_OK;
        r.found_pos = '0;
        p           = int'(pos);
        hit         = 1'b0;
        case (kind)
            KIND_INS_HEAD, KIND_INS_TAIL, KIND_INS_POS: begin
                // full check wins over the position check
                if (list_len >= CAPACITY) r.status = STAT_FULL;
                else if (list_len == 0 || kind == KIND_INS_HEAD) insert_entry(0, value);
                else if (kind == KIND_INS_TAIL) insert_entry(list_len, value);
                else if (p <= 1) insert_entry(0, value);
                else if (p <= list_len + 1) insert_entry(p - 1, value);
                else r.status = STAT_BADPOS;
            end
            KIND_DEL_HEAD, KIND_DEL_TAIL, KIND_DEL_POS: begin
                if (list_len == 0) r.status = STAT_EMPTY;
                else if (kind == KIND_DEL_HEAD) remove_entry(0);
                else if (kind == KIND_DEL_TAIL) remove_entry(list_len - 1);
                else if (p <= 1) remove_entry(0);
                else if (p <= list_len) remove_entry(p - 1);
                else r.status = STAT_BADPOS;
            end
            KIND_SEARCH: begin
                if (list_len == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    r.status = STAT_NOTFOUND;
                    for (int i = 0; i < list_len; i++) begin
                        if (!hit && list_mem[i] == value) begin
                            hit         = 1'b1;
                            r.status    = STAT_OK;
                            r.found_pos = POS_W'(i + 1);
                        end
                    end
                end
            end
            default: ;  // unused kind: no operation
        endcase
        r.entry_count = POS_W'(list_len);
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            list_len = 0;
            result_q.delete();
            pending <= 0;
        end else begin
            // retire the result beat first: it can never belong to this edge's input beat
            if (m_tvalid && m_tready) begin
                if (result_q.size() == 0) begin
                    $error("result beat with nothing outstanding: m_tdata=%h", m_tdata);
                    fail_count++;
                end else begin
                    want = result_q.pop_front();
                    if (m_tdata[STAT_W-1:0] !== want.status) begin
                        $error("status: expected %0d, actual %0d",
                               want.status, m_tdata[STAT_W-1:0]);
                        fail_count++;
                    end
                    if (m_tdata[FOUND_LSB +: POS_W] !== want.found_pos) begin
                        $error("found_position: expected %0d, actual %0d",
                               want.found_pos, m_tdata[FOUND_LSB +: POS_W]);
                        fail_count++;
                    end
                    if (m_tdata[COUNT_LSB +: POS_W] !== want.entry_count) begin
                        $error("entry_count: expected %0d, actual %0d",
                               want.entry_count, m_tdata[COUNT_LSB +: POS_W]);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                result_q.push_back(apply_list_op(s_tuser, s_tdata[ENTRY_W-1:0],
                                                 s_tdata[ENTRY_W +: POS_W]));
            end
            pending <= result_q.size();
        end
    end

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives list operations into the ordered list block: a short directed run
// over the empty, bad position and first-match cases, then random segments
// that push the list toward full, toward empty or mix every kind. Idling on
// both sides changes by phase; the checker beside the block does the scoring.
// ----------------------------------------------------------------------------
module tb_top;
    import olids_pkg::*;

    localparam int CAPACITY     = 16;
    localparam int RANDOM_ITEMS = 1700;
    localparam int PHASE_ITEMS  = RANDOM_ITEMS / 4;
    localparam int HOLD_CYCLES  = 300;     // long receiver hold-off
    localparam int HOLD_AFTER   = 120;     // beats sent before the hold-off starts
    localparam int DRAIN_CYCLES = 4 * (CAPACITY + 2);
    localparam int CYCLE_LIMIT  = 400000;
    localparam int POOL_DEPTH   = 24;

    // the one 3-bit code that names no operation
    localparam logic [KIND_W-1:0]  KIND_UNUSED = 3'd7;
    localparam logic [ENTRY_W-1:0] VAL_MAX     = 32'h7fff_ffff;
    localparam logic [ENTRY_W-1:0] VAL_MIN     = 32'h8000_0000;
    localparam logic [ENTRY_W-1:0] VAL_ONES    = 32'hffff_ffff;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [KIND_W-1:0]    s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    int   fail_count;
    int   pending;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   sent_items     = 0;
    int   cycle_cnt      = 0;
    logic long_hold      = 1'b0;

    // recently inserted values, so that searches hit now and then
    logic [ENTRY_W-1:0] value_pool [$];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    ordered_list_insert_delete_search #(
        .CAPACITY (CAPACITY)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    ordered_list_checker #(
        .CAPACITY (CAPACITY)
    ) u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Receiver: stall at the phase's rate, or hold off entirely during the long stretch.
    always @(posedge aclk) begin
        if (long_hold) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Hold off the receiver for a long stretch while the sender keeps offering
    // beats, so the output backs up and the block drops s_tready.
    initial begin
        wait (sent_items >= HOLD_AFTER);
        @(posedge aclk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        long_hold <= 1'b0;
    end

    // Watchdog: end the run if it hangs.
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Offer one beat and hold it until accepted. Called right after a rising edge;
    // drop s_tvalid only for the idle cycles in front of the beat.
    task automatic send_item(input logic [KIND_W-1:0] kind,
                             input logic [ENTRY_W-1:0] value,
                             input logic [POS_W-1:0] pos);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {{(S_TDATA_W - ENTRY_W - POS_W){1'b0}}, pos, value};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_items++;
        if (kind == KIND_INS_HEAD || kind == KIND_INS_TAIL || kind == KIND_INS_POS) begin
            value_pool.push_back(value);
            if (value_pool.size() > POOL_DEPTH) void'(value_pool.pop_front());
        end
    endtask

    // Mostly full-range random values, with the extremes and a small range
    // that makes duplicate entries likely.
    function automatic logic [ENTRY_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 11);
        if (sel == 0) return VAL_MAX;
        if (sel == 1) return VAL_MIN;
        if (sel == 2) return VAL_ONES;
        if (sel <= 4) return ENTRY_W'($urandom_range(0, 7));
        return $urandom();
    endfunction

    // One random segment: a run of inserts that pushes toward full, a run of
    // deletes that pushes toward empty, or a mix of every kind with many searches.
    task automatic run_segment();
        int                 mode;
        int                 len;
        int                 sel;
        logic [KIND_W-1:0]  kind;
        logic [ENTRY_W-1:0] value;
        logic [POS_W-1:0]   pos;
        mode = $urandom_range(0, 9);
        len  = (mode < 5) ? $urandom_range(16, 24) : $urandom_range(8, 24);
        for (int i = 0; i < len; i++) begin
            value = pick_value();
            if (mode < 3) begin
                kind = KIND_W'($urandom_range(KIND_INS_HEAD, KIND_INS_POS));
                pos  = POS_W'($urandom_range(0, CAPACITY + 2));
            end else if (mode < 5) begin
                kind = KIND_W'($urandom_range(KIND_DEL_HEAD, KIND_DEL_POS));
                pos  = POS_W'($urandom_range(0, CAPACITY + 2));
            end else begin
                sel = $urandom_range(0, 99);
                pos = POS_W'($urandom());
                if (sel < 30) begin
                    kind = KIND_SEARCH;
                    if (value_pool.size() > 0 && $urandom_range(0, 9) < 7) begin
                        value = value_pool[$urandom_range(0, value_pool.size() - 1)];
                    end
                end else if (sel < 33) begin
                    kind = KIND_UNUSED;
                end else begin
                    kind = KIND_W'($urandom_range(KIND_INS_HEAD, KIND_DEL_POS));
                end
            end
            send_item(kind, value, pos);
        end
    endtask

    initial begin
        int start_cnt;

        // hold reset, then release it once for the whole run
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty list, head-forced insert, bad positions, extremes,
        // first-match search with a duplicate, no match, unused kind.
        send_item(KIND_SEARCH,   32'd1,        5'd0);
        send_item(KIND_DEL_HEAD, 32'd0,        5'd0);
        send_item(KIND_DEL_TAIL, 32'd0,        5'd0);
        send_item(KIND_DEL_POS,  32'd0,        5'd7);
        send_item(KIND_UNUSED,   VAL_ONES,     5'd31);
        send_item(KIND_INS_POS,  VAL_MAX,      5'd31);   // empty list: lands at head
        send_item(KIND_INS_POS,  32'd9,        5'd3);    // past count+1: rejected
        send_item(KIND_INS_POS,  VAL_MIN,      5'd2);    // count+1: appends
        send_item(KIND_INS_HEAD, 32'd0,        5'd0);
        send_item(KIND_INS_TAIL, VAL_ONES,     5'd0);
        send_item(KIND_INS_POS,  32'd5,        5'd0);    // position 0 means head
        send_item(KIND_INS_POS,  32'd0,        5'd1);    // duplicate of a later entry
        send_item(KIND_SEARCH,   32'd0,        5'd0);    // first match wins
        send_item(KIND_SEARCH,   VAL_MIN,      5'd0);
        send_item(KIND_SEARCH,   32'h1234_5678, 5'd0);   // no match
        send_item(KIND_DEL_POS,  32'd0,        5'd31);   // past count: rejected
        send_item(KIND_DEL_POS,  32'd0,        5'd6);    // last entry
        send_item(KIND_DEL_POS,  32'd0,        5'd0);
        send_item(KIND_DEL_TAIL, 32'd0,        5'd0);
        send_item(KIND_DEL_HEAD, 32'd0,        5'd0);

        // Random phases: no idling, sender gaps, receiver stalls, both.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            start_cnt = sent_items;
            while (sent_items - start_cnt < PHASE_ITEMS) run_segment();
        end
        s_tvalid <= 1'b0;
        recv_stall_pct = 0;

        // drain the outstanding results, then give a stray beat time to show up
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/olids_pkg.sv
rtl/olids_cell.sv
rtl/olids_scan.sv
rtl/ordered_list_insert_delete_search.sv
dv/ordered_list_checker.sv
dv/tb_top.sv
